### design/ppu_pkg.sv
// Shared types and constants for the penalty weight update block.
`timescale 1ns / 1ps

package ppu_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WEIGHT_FLOOR     = 3'd0;
    localparam logic [2:0] CFG_RATIO_TO_MAX     = 3'd1;
    localparam logic [2:0] CFG_GROWTH_FACTOR    = 3'd2;
    localparam logic [2:0] CFG_NEAR_THRESHOLD   = 3'd3;
    localparam logic [2:0] CFG_CONSTRAINT_COUNT = 3'd4;

    // One in Q0.16 with the integer bit, and the width of the shared multiplier.
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic signed [31:0] multiplier;
        logic [31:0]        opt_error;
        logic               external_set;
        logic [31:0]        external_value;
        logic               final_element;
    } ppu_in_t;

    typedef struct packed {
        logic [31:0] weight;
        logic [5:0]  weight_index;
        logic [31:0] largest_weight;
        logic        near_mode;
        logic        run_end;
    } ppu_out_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ppu_mem_ctl_t;

endpackage

### design/penalty_param_update.sv
// Top level of the penalty weight update block: sequencer, registers and output stage.
`timescale 1ns / 1ps
//
// Each input transfer carries one Lagrange multiplier and updates the stored
// penalty weight at the next constraint index of the current run. The input
// channel (in_valid/in_stall) takes one transfer, then holds in_stall high
// while the item is worked: a read of the weight memory, one pass through the
// shared multiplier for the growth term, and a write back.
// On an item marked final_element the block uses the same multiplier once more
// for the ratio floor and then walks the weights of the run, one memory read
// and one write back per weight; a final item skipped by a matching external
// weight ends the run with no walk. Results leave through an output register
// (out_valid/out_stall); a stalled result holds and the walk waits on it. After
// the last result is loaded the block accepts the next item while that result
// still waits. Configuration writes (cfg_valid/cfg_ready) are always taken and
// should be made only while the block is idle. Reset returns the control and
// configuration registers to their reset values and clears the mode and the
// stored weights at once; no sweep of the memory is needed.
//

module penalty_param_update #(
    parameter int MAX_CONSTRAINTS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ppu_pkg::ppu_in_t  in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output ppu_pkg::ppu_out_t out_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import ppu_pkg::*;

    localparam int AW = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
    localparam int CW = $clog2(MAX_CONSTRAINTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_WRD  = 3'd4;
    localparam logic [2:0] S_WEM  = 3'd5;

    // Configuration registers.
    logic [31:0] floor_reg;
    logic [16:0] ratio_reg;
    logic [15:0] growth_reg;
    logic [31:0] thresh_reg;
    logic [6:0]  ccount_reg;

    logic [2:0]    state_reg, state_next;
    logic [31:0]   mag_reg, mag_next;
    logic [31:0]   kkt_reg, kkt_next;
    logic          skip_reg, skip_next;
    logic          final_reg, final_next;
    logic          near_reg, near_next;
    logic [31:0]   prev_max_reg, prev_max_next;
    logic [31:0]   run_max_reg, run_max_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] walk_reg, walk_next;
    logic          out_valid_reg, out_valid_next;
    ppu_out_t      out_item_reg, out_item_next;

    logic          in_fire;
    logic [CW-1:0] eff_count;
    logic [CW-1:0] run_len;
    logic          in_range;
    logic          walk_last;
    logic          out_free;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_en;
    logic [MUL_P_W-1:0] mul_prod;

    ppu_mem_ctl_t mem_ctl;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata;
    logic [31:0]   mem_rdata;

    logic [31:0] grown;
    logic [33:0] avg_sum;
    logic [31:0] base_w;
    logic [31:0] upd_w;
    logic [31:0] ratio_floor;
    logic [31:0] walk_w;
    logic [16:0] ratio_eff;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (ccount_reg == 7'd0)
        begin
            eff_count = CW'(1);
        end
        else if (ccount_reg > 7'(MAX_CONSTRAINTS))
        begin
            eff_count = CW'(MAX_CONSTRAINTS);
        end
        else
        begin
            eff_count = CW'(ccount_reg);
        end
    end

    assign in_range  = (count_reg < eff_count);
    assign run_len   = (count_reg < eff_count) ? count_reg : eff_count;
    assign walk_last = (walk_reg == CW'(run_len - CW'(1)));
    assign ratio_eff = (ratio_reg > ONE_Q16) ? ONE_Q16 : ratio_reg;

    // The shared multiplier serves the growth term and later the ratio floor.
    assign mul_en = (state_reg == S_MUL) || (state_reg == S_FIN);
    assign mul_a  = (state_reg == S_FIN) ? ratio_eff : (ONE_Q16 + {1'b0, growth_reg});
    assign mul_b  = (state_reg == S_FIN) ? run_max_reg : mag_reg;

    ppu_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    assign grown       = mul_prod[MUL_P_W-1] ? 32'hFFFF_FFFF : mul_prod[47:16];
    assign ratio_floor = mul_prod[47:16];

    // Truncated average (3*old + |m|) / 4; the sum never exceeds 34 bits.
    assign avg_sum = {2'b00, mem_rdata} + {1'b0, mem_rdata, 1'b0} + {2'b00, mag_reg};

    always_comb
    begin
        base_w = near_reg ? mem_rdata : avg_sum[33:2];
        upd_w  = (base_w > grown) ? base_w : grown;
        if (floor_reg > upd_w)
        begin
            upd_w = floor_reg;
        end
        if (skip_reg)
        begin
            upd_w = mem_rdata;
        end
        walk_w = (mem_rdata > ratio_floor) ? mem_rdata : ratio_floor;
    end

    always_comb
    begin
        mem_ctl.rd_en = in_fire || (state_reg == S_WRD);
        mem_ctl.wr_en = ((state_reg == S_UPD) && in_range && !skip_reg)
                     || ((state_reg == S_WEM) && out_free);
        mem_addr  = ((state_reg == S_WRD) || (state_reg == S_WEM))
                  ? walk_reg[AW-1:0] : count_reg[AW-1:0];
        mem_wdata = (state_reg == S_WEM) ? walk_w : upd_w;
    end

    ppu_store #(
        .DEPTH (MAX_CONSTRAINTS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        kkt_next       = kkt_reg;
        skip_next      = skip_reg;
        final_next     = final_reg;
        near_next      = near_reg;
        prev_max_next  = prev_max_reg;
        run_max_next   = run_max_reg;
        count_next     = count_reg;
        walk_next      = walk_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    mag_next   = in_item.multiplier[31] ? (32'd0 - in_item.multiplier)
                                                        : in_item.multiplier;
                    kkt_next   = in_item.opt_error;
                    skip_next  = in_item.external_set
                              && (in_item.external_value == prev_max_reg);
                    final_next = in_item.final_element;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (in_range)
                begin
                    run_max_next = (run_max_reg > upd_w) ? run_max_reg : upd_w;
                    count_next   = count_reg + CW'(1);
                end
                state_next = final_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                walk_next = '0;
                if (skip_reg)
                begin
                    count_next   = '0;
                    run_max_next = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    if (kkt_reg <= thresh_reg)
                    begin
                        near_next = 1'b1;
                    end
                    state_next = S_WRD;
                end
            end
            S_WRD:
            begin
                state_next = S_WEM;
            end
            S_WEM:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_item_next.weight         = walk_w;
                    out_item_next.weight_index   = 6'(walk_reg[AW-1:0]);
                    out_item_next.largest_weight = run_max_reg;
                    out_item_next.near_mode      = near_reg;
                    out_item_next.run_end        = walk_last;
                    if (walk_last)
                    begin
                        prev_max_next = run_max_reg;
                        run_max_next  = '0;
                        count_next    = '0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        walk_next  = walk_reg + CW'(1);
                        state_next = S_WRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            near_reg      <= 1'b0;
            prev_max_reg  <= '0;
            run_max_reg   <= '0;
            count_reg     <= '0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
            skip_reg      <= 1'b0;
            final_reg     <= 1'b0;
            floor_reg     <= '0;
            ratio_reg     <= '0;
            growth_reg    <= '0;
            thresh_reg    <= '0;
            ccount_reg    <= 7'd64;
        end
        else
        begin
            state_reg     <= state_next;
            near_reg      <= near_next;
            prev_max_reg  <= prev_max_next;
            run_max_reg   <= run_max_next;
            count_reg     <= count_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
            skip_reg      <= skip_next;
            final_reg     <= final_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WEIGHT_FLOOR:     floor_reg  <= cfg_data;
                    CFG_RATIO_TO_MAX:     ratio_reg  <= cfg_data[16:0];
                    CFG_GROWTH_FACTOR:    growth_reg <= cfg_data[15:0];
                    CFG_NEAR_THRESHOLD:   thresh_reg <= cfg_data;
                    CFG_CONSTRAINT_COUNT: ccount_reg <= cfg_data[6:0];
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        kkt_reg      <= kkt_next;
        out_item_reg <= out_item_next;
    end

endmodule

### design/ppu_mul.sv
// Shared 17 x 32 unsigned multiplier with a registered product.
`timescale 1ns / 1ps

module ppu_mul (
    input  logic                         clk,
    input  logic                         en,
    input  logic [ppu_pkg::MUL_A_W-1:0]  a,
    input  logic [ppu_pkg::MUL_B_W-1:0]  b,
    output logic [ppu_pkg::MUL_P_W-1:0]  prod
);
    import ppu_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

### design/ppu_store.sv
// Penalty weight memory with one shared port and per-entry valid bits.
`timescale 1ns / 1ps

module ppu_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppu_pkg::ppu_mem_ctl_t ctl,
    input  logic [AW-1:0]         addr,
    input  logic [31:0]           wdata,
    output logic [31:0]           rdata
);
    import ppu_pkg::*;

    logic [31:0]      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [31:0]      rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : 32'd0;

endmodule

### tb/sv/ppu_weight_checker.sv
// Checker for the penalty weight update block: watches all channels, predicts and compares.
`timescale 1ns / 1ps

module ppu_weight_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  ppu_pkg::ppu_in_t  in_item,
    input  logic              out_valid,
    input  logic              out_stall,
    input  ppu_pkg::ppu_out_t out_item,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output int                fail_count,
    output int                pending,
    output int                results_checked,
    output logic [31:0]       prev_max_hint,
    output logic              near_hint
);
    import ppu_pkg::*;

    localparam int MAX_CONSTRAINTS = 64;
    localparam int MAX_PRINTS      = 60;

    logic [31:0] floor_reg;
    logic [16:0] ratio_reg;
    logic [15:0] growth_reg;
    logic [31:0] thresh_reg;
    logic [6:0]  count_reg;

    logic [31:0] weight_model [MAX_CONSTRAINTS];
    logic        near_mode_model;
    logic [31:0] previous_max_model;
    logic [31:0] running_max_model;
    logic [6:0]  run_position;

    ppu_out_t expected_weights [$];

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTS)
        begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        fail_count = fail_count + 1;
    endtask

    function automatic logic [31:0] grown_weight(input logic [31:0] old_w,
                                                 input logic [31:0] mag);
        logic [63:0] grown;
        logic [63:0] avg;
        logic [31:0] sat;
        logic [31:0] base;
        logic [31:0] best;
        grown = ((64'(ONE_Q16) + 64'(growth_reg)) * 64'(mag)) >> 16;
        sat   = (grown > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
        avg   = (64'd3 * 64'(old_w) + 64'(mag)) >> 2;
        // Near the solution the old weight is kept instead of being averaged down.
        base  = near_mode_model ? old_w : avg[31:0];
        best  = (base > sat) ? base : sat;
        return (best > floor_reg) ? best : floor_reg;
    endfunction

    task automatic predict_weight_update(input ppu_in_t item);
        logic        skip;
        logic [31:0] raw;
        logic [31:0] mag;
        logic [31:0] ratio_floor;
        logic [31:0] w;
        logic [63:0] prod;
        logic [16:0] ratio;
        int          eff;
        int          n;
        logic [5:0]  slot;
        ppu_out_t    r;

        raw  = item.multiplier;
        skip = item.external_set && (item.external_value == previous_max_model);
        eff  = (count_reg == 7'd0) ? 1 :
               (count_reg > MAX_CONSTRAINTS) ? MAX_CONSTRAINTS : int'(count_reg);
        mag  = raw[31] ? (32'd0 - raw) : raw;

        // Items past the constraint count leave the store alone.
        if (int'(run_position) < eff)
        begin
            slot = run_position[5:0];
            if (!skip)
            begin
                weight_model[slot] = grown_weight(weight_model[slot], mag);
            end
            if (weight_model[slot] > running_max_model)
            begin
                running_max_model = weight_model[slot];
            end
            run_position = run_position + 7'd1;
        end

        if (item.final_element)
        begin
            n = (int'(run_position) < eff) ? int'(run_position) : eff;
            if (skip)
            begin
                run_position      = 7'd0;
                running_max_model = 32'd0;
            end
            else
            begin
                if (!near_mode_model && item.opt_error <= thresh_reg)
                begin
                    near_mode_model = 1'b1;
                end
                ratio       = (ratio_reg > ONE_Q16) ? ONE_Q16 : ratio_reg;
                prod        = 64'(ratio) * 64'(running_max_model);
                ratio_floor = prod[47:16];
                for (int i = 0; i < n; i++)
                begin
                    w = (weight_model[i] > ratio_floor) ? weight_model[i] : ratio_floor;
                    weight_model[i]  = w;
                    r.weight         = w;
                    r.weight_index   = 6'(i);
                    r.largest_weight = running_max_model;
                    r.near_mode      = near_mode_model;
                    r.run_end        = (i == n - 1);
                    expected_weights.push_back(r);
                end
                previous_max_model = running_max_model;
                running_max_model  = 32'd0;
                run_position       = 7'd0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg          = 32'd0;
            ratio_reg          = 17'd0;
            growth_reg         = 16'd0;
            thresh_reg         = 32'd0;
            count_reg          = 7'd64;
            near_mode_model    = 1'b0;
            previous_max_model = 32'd0;
            running_max_model  = 32'd0;
            run_position       = 7'd0;
            for (int i = 0; i < MAX_CONSTRAINTS; i++)
            begin
                weight_model[i] = 32'd0;
            end
            expected_weights.delete();
            fail_count      = 0;
            results_checked = 0;
            pending       <= 0;
            prev_max_hint <= 32'd0;
            near_hint     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WEIGHT_FLOOR:     floor_reg  = cfg_data;
                    CFG_RATIO_TO_MAX:     ratio_reg  = cfg_data[16:0];
                    CFG_GROWTH_FACTOR:    growth_reg = cfg_data[15:0];
                    CFG_NEAR_THRESHOLD:   thresh_reg = cfg_data;
                    CFG_CONSTRAINT_COUNT: count_reg  = cfg_data[6:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                predict_weight_update(in_item);
            end

            if (out_valid && !out_stall)
            begin
                if (expected_weights.size() == 0)
                begin
                    report_mismatch($sformatf("weight %h at index %0d with nothing expected",
                                              out_item.weight, out_item.weight_index));
                end
                else
                begin
                    ppu_out_t want;
                    want = expected_weights.pop_front();
                    results_checked = results_checked + 1;
                    if (out_item.weight !== want.weight)
                        report_mismatch($sformatf("index %0d: weight %h, expected %h",
                                                  want.weight_index, out_item.weight,
                                                  want.weight));
                    if (out_item.weight_index !== want.weight_index)
                        report_mismatch($sformatf("weight_index %0d, expected %0d",
                                                  out_item.weight_index, want.weight_index));
                    if (out_item.largest_weight !== want.largest_weight)
                        report_mismatch($sformatf("index %0d: largest_weight %h, expected %h",
                                                  want.weight_index, out_item.largest_weight,
                                                  want.largest_weight));
                    if (out_item.near_mode !== want.near_mode)
                        report_mismatch($sformatf("index %0d: near_mode %b, expected %b",
                                                  want.weight_index, out_item.near_mode,
                                                  want.near_mode));
                    if (out_item.run_end !== want.run_end)
                        report_mismatch($sformatf("index %0d: run_end %b, expected %b",
                                                  want.weight_index, out_item.run_end,
                                                  want.run_end));
                end
            end

            pending       <= expected_weights.size();
            prev_max_hint <= previous_max_model;
            near_hint     <= near_mode_model;
        end
    end

endmodule

### tb/sv/tb_penalty_param_update.sv
// Testbench top for the penalty weight update block: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_penalty_param_update;
    import ppu_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int SEGMENT_ITEMS  = 45;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    ppu_in_t     in_item   = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = CFG_WEIGHT_FLOOR;
    logic [31:0] cfg_data  = 32'd0;

    logic        in_stall;
    logic        out_valid;
    ppu_out_t    out_item;
    logic        cfg_ready;

    int          fail_count;
    int          pending;
    int          results_checked;
    logic [31:0] prev_max_hint;
    logic        near_hint;

    int          send_idle_pct = 11;
    int          recv_idle_pct = 48;
    int          quiet_cycles  = 0;
    int          items_sent    = 0;
    int          runs_sent     = 0;
    int          settings_used = 0;
    int          cur_eff       = 64;
    logic        near_allowed  = 1'b0;

    penalty_param_update uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ppu_weight_checker weight_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_item         (in_item),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_item        (out_item),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .prev_max_hint   (prev_max_hint),
        .near_hint       (near_hint)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Any transfer on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("tb_penalty_param_update NOT OK");
            $finish;
        end
    end

    function automatic ppu_in_t make_item(input logic [31:0] mult, input logic [31:0] kkt,
                                          input logic ext_set, input logic [31:0] ext_val,
                                          input logic last);
        ppu_in_t item;
        item.multiplier     = mult;
        item.opt_error      = kkt;
        item.external_set   = ext_set;
        item.external_value = ext_val;
        item.final_element  = last;
        return item;
    endfunction

    function automatic logic [31:0] rand_mult();
        logic [31:0] v;
        case ($urandom_range(9))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2, 3:    v = $urandom;
            default:
            begin
                v = $urandom_range(0, 32'h0003_FFFF);
                if ($urandom_range(1) == 1)
                    v = 32'd0 - v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_kkt();
        logic [31:0] k;
        k = $urandom;
        if ($urandom_range(9) == 0)
            k = $urandom_range(0, 255);
        // Keep the mode off while the threshold is zero and normal mode is under test.
        if (!near_allowed && k == 32'd0)
            k = 32'd1;
        return k;
    endfunction

    task automatic send_item(input ppu_in_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_item  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent = items_sent + 1;
        if (item.final_element)
            runs_sent = runs_sent + 1;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [31:0] floor_v, input logic [31:0] ratio_v,
                                input logic [31:0] growth_v, input logic [31:0] thresh_v,
                                input logic [31:0] count_v);
        logic [2:0]  reg_ids  [5];
        logic [31:0] reg_vals [5];
        reg_ids  = '{CFG_WEIGHT_FLOOR, CFG_RATIO_TO_MAX, CFG_GROWTH_FACTOR,
                     CFG_NEAR_THRESHOLD, CFG_CONSTRAINT_COUNT};
        reg_vals = '{floor_v, ratio_v, growth_v, thresh_v, count_v};
        settle();
        for (int i = 0; i < 5; i++)
        begin
            cfg_index <= reg_ids[i];
            cfg_data  <= reg_vals[i];
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_eff = (count_v[6:0] == 7'd0) ? 1 : (count_v[6:0] > 7'd64) ? 64 : int'(count_v[6:0]);
        settings_used = settings_used + 1;
    endtask

    task automatic send_run(input int len);
        int          r;
        logic        ext_set;
        logic [31:0] ext_val;
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(99);
            if (r < 15)
            begin
                ext_set = 1'b1;
                ext_val = prev_max_hint;
            end
            else
            begin
                ext_set = (r < 30);
                ext_val = $urandom;
            end
            send_item(make_item(rand_mult(), rand_kkt(), ext_set, ext_val, i == len - 1));
        end
        // Now and then hold the sender until every weight of the run has come out.
        if ($urandom_range(9) == 0)
            drain();
    endtask

    task automatic run_segment(input int count);
        int start;
        int r;
        int len;
        start = items_sent;
        while (items_sent - start < count)
        begin
            r = $urandom_range(99);
            if (r < 70)
                len = $urandom_range(1, (cur_eff < 6) ? cur_eff : 6);
            else if (r < 90)
                len = $urandom_range(1, cur_eff);
            else
                len = cur_eff + $urandom_range(1, 3);
            send_run(len);
        end
    endtask

    initial
    begin
        logic [31:0] boundary_kkt;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_regs(32'h0001_0000, 32'h0001_0000, 32'h0000_FFFF, 32'h0, 32'd4);

        // Extreme multipliers in one full run.
        send_item(make_item(32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0));
        send_item(make_item(32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 32'hFFFF_FFFF, 1'b0));
        send_item(make_item(32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0));
        send_item(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b1));
        drain();

        // More items than constraints; the external weight does not match.
        for (int i = 0; i < 6; i++)
            send_item(make_item(rand_mult(), 32'hFFFF_FFFF, 1'b1, prev_max_hint + 32'd1,
                                i == 5));
        drain();

        // First item skipped by a matching external weight.
        send_item(make_item(32'h0001_0000, 32'hFFFF_FFFF, 1'b1, prev_max_hint, 1'b0));
        send_item(make_item(32'hFFFF_0000, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b1));
        drain();

        // Final item skipped: the run ends with nothing emitted.
        send_item(make_item(32'h0000_8000, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0));
        send_item(make_item(32'h0000_8000, 32'hFFFF_FFFF, 1'b1, prev_max_hint, 1'b1));
        send_item(make_item(32'h0000_0000, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1));

        program_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'd1);
        run_segment(SEGMENT_ITEMS);
        program_regs($urandom_range(0, 32'h0040_0000), $urandom_range(0, 65536),
                     $urandom_range(0, 65535), 32'h0, 32'd64);
        run_segment(SEGMENT_ITEMS);

        send_idle_pct = 48;
        recv_idle_pct = 11;
        program_regs(32'hFFFF_FFFF, $urandom_range(0, 65536), 32'h0000_FFFF, 32'h0, 32'd0);
        run_segment(SEGMENT_ITEMS);
        program_regs($urandom_range(0, 32'h0040_0000), 32'h0001_FFFF,
                     $urandom_range(0, 65535), 32'h0, 32'd127);
        run_segment(SEGMENT_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        near_allowed  = 1'b1;
        boundary_kkt  = $urandom;
        program_regs($urandom_range(0, 32'h0040_0000), $urandom_range(0, 65536),
                     $urandom_range(0, 65535), boundary_kkt, $urandom_range(1, 64));
        // A KKT error equal to the threshold switches to near-solution mode.
        send_item(make_item(rand_mult(), boundary_kkt, 1'b0, 32'h0, 1'b1));
        run_segment(SEGMENT_ITEMS - 1);
        program_regs(32'h0, 32'h0001_0000, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'd64);
        run_segment(SEGMENT_ITEMS);

        settle();

        $display("Sent %0d multipliers in %0d runs under %0d register settings; %0d weights checked.",
                 items_sent, runs_sent, settings_used, results_checked);
        $display("Near-solution mode %s by the end.", near_hint ? "was active" : "was never active");
        if (fail_count == 0 && pending == 0)
        begin
            $display("tb_penalty_param_update OK");
        end
        else
        begin
            $display("%0d mismatches, %0d weights still expected", fail_count, pending);
            $display("tb_penalty_param_update NOT OK");
        end
        $finish;
    end

endmodule
